FILE: design/hsk_pkg.sv
package hsk_pkg;

    // capacity of the value store
    localparam int MAX_ITEMS = 64;

    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int RANK_W = 7;
    localparam int KCMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // APB register map
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_KTH   = 0;

    typedef logic signed [DATA_W-1:0] t_value;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [RANK_W-1:0]        t_rank;
    typedef logic [KCMP_W-1:0]        t_kcmp;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BSTART,
        ST_BCUR,
        ST_RDL,
        ST_RDR,
        ST_CMP,
        ST_ERD0,
        ST_ERDE,
        ST_ESWAP,
        ST_ORD,
        ST_OWAIT
    } t_state;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_value wdata;
        t_idx   raddr;
    } t_ram_req;

endpackage

FILE: design/heap_sort_with_kth_largest.sv
// Heap sort with kth-largest flag. Signed 32-bit values stream in on the
// slave side, one per transfer, up to 64 per set; values past 64 are
// dropped. The transfer with tlast closes the set: the block builds a max
// heap in its 64x32 RAM, sorts it in place, then streams the set out in
// ascending order on the master side, tlast on the final value and tuser
// on the kth largest (kth_rank register at APB address 0, reset 1; 0 acts
// as 1, a rank at or above the set size flags the smallest value).
// Values are accepted back to back while loading. After the tlast transfer
// the sort runs with slave tready low: each sift-down level steps through
// left read, right read, then compare and write back on the single-port-
// read RAM, after a fetch of the sift start, and each extract swap reads
// the root, reads the end and writes the swap. Readout moves each value
// from the RAM read register to the output register; master stalls hold it.
// The final result sits in an output register, so the next set's loading
// starts while it waits. No clearing pass is needed after reset.
module heap_sort_with_kth_largest (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [31:0]                i_s_tdata,   // [31:0] value
    input  logic                       i_s_tlast,   // last value of the set
    // sorted stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [31:0]                o_m_tdata,   // [31:0] sorted_value
    output logic                       o_m_tuser,   // [0] is_kth
    output logic                       o_m_tlast,   // end_of_run
    // configuration
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [hsk_pkg::APB_AW-1:0] i_paddr,
    input  logic [hsk_pkg::APB_DW-1:0] i_pwdata,
    output logic [hsk_pkg::APB_DW-1:0] o_prdata,
    output logic                       o_pready
);

    hsk_pkg::t_rank    r_kth_rank;
    hsk_pkg::t_ram_req ram_req;
    hsk_pkg::t_value   ram_rdata;
    logic              sel_kth;
    logic [hsk_pkg::DATA_W-1:0] rdata_raw;

    // word-addressed register decode
    assign sel_kth  = (i_paddr[hsk_pkg::APB_AW-1:2]
                       == (hsk_pkg::APB_AW - 2)'(hsk_pkg::REG_KTH));
    assign o_pready = 1'b1;
    assign o_prdata = sel_kth ? hsk_pkg::APB_DW'(r_kth_rank) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kth_rank <= hsk_pkg::t_rank'(1);
        end else if (i_psel && i_penable && i_pwrite && o_pready && sel_kth) begin
            r_kth_rank <= i_pwdata[hsk_pkg::RANK_W-1:0];
        end
    end

    hsk_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_kth_rank  (r_kth_rank),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    // heap storage
    hsk_ram #(
        .WIDTH (hsk_pkg::DATA_W),
        .DEPTH (hsk_pkg::MAX_ITEMS)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata_raw)
    );

    assign ram_rdata = hsk_pkg::t_value'(rdata_raw);

endmodule

FILE: design/hsk_ram.sv
module hsk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/hsk_engine.sv
module hsk_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // [31:0] value
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,   // [31:0] sorted_value
    output logic              o_m_tuser,   // [0] is_kth
    output logic              o_m_tlast,
    input  hsk_pkg::t_rank    i_kth_rank,
    output hsk_pkg::t_ram_req o_ram_req,
    input  hsk_pkg::t_value   i_ram_rdata
);

    hsk_pkg::t_state r_state, n_state;
    hsk_pkg::t_cnt   r_count, n_count;
    hsk_pkg::t_cnt   r_size, n_size;
    hsk_pkg::t_cnt   r_n, n_n;
    hsk_pkg::t_idx   r_b, n_b;
    hsk_pkg::t_idx   r_idx, n_idx;
    hsk_pkg::t_idx   r_j, n_j;
    hsk_pkg::t_idx   r_kpos, n_kpos;
    hsk_pkg::t_value r_cur, n_cur;
    hsk_pkg::t_value r_lval, n_lval;
    logic            r_build, n_build;
    logic            r_ovalid, n_ovalid;
    hsk_pkg::t_value r_odata, n_odata;
    logic            r_okth, n_okth;
    logic            r_olast, n_olast;

    hsk_pkg::t_cnt   lc, rc, total, last_cnt;
    logic            l_ok, r_ok, pick_r, stored, accept, out_free;
    hsk_pkg::t_value big_val;
    hsk_pkg::t_idx   big_idx;
    hsk_pkg::t_kcmp  k_eff, n_ext;
    hsk_pkg::t_ram_req ram;

    // children of the current sift position
    assign lc     = {r_idx, 1'b1};
    assign rc     = lc + hsk_pkg::t_cnt'(1);
    assign l_ok   = lc < r_size;
    assign r_ok   = rc < r_size;
    assign pick_r = r_ok && (i_ram_rdata > r_lval);
    assign big_val = pick_r ? i_ram_rdata : r_lval;
    assign big_idx = pick_r ? rc[hsk_pkg::IDX_W-1:0] : lc[hsk_pkg::IDX_W-1:0];

    assign o_s_tready = (r_state == hsk_pkg::ST_LOAD);
    assign accept   = i_s_tvalid && o_s_tready;
    assign stored   = r_count < hsk_pkg::t_cnt'(hsk_pkg::MAX_ITEMS);
    assign total    = r_count + hsk_pkg::t_cnt'(stored);
    assign last_cnt = r_n - hsk_pkg::t_cnt'(1);
    assign out_free = !r_ovalid || i_m_tready;

    assign k_eff = (i_kth_rank == '0) ? hsk_pkg::t_kcmp'(1) : hsk_pkg::t_kcmp'(i_kth_rank);
    assign n_ext = hsk_pkg::t_kcmp'(total);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_size   = r_size;
        n_n      = r_n;
        n_b      = r_b;
        n_idx    = r_idx;
        n_j      = r_j;
        n_kpos   = r_kpos;
        n_cur    = r_cur;
        n_lval   = r_lval;
        n_build  = r_build;
        n_odata  = r_odata;
        n_okth   = r_okth;
        n_olast  = r_olast;
        n_ovalid = r_ovalid && !i_m_tready;
        ram.we    = 1'b0;
        ram.waddr = r_idx;
        ram.wdata = r_cur;
        ram.raddr = r_j;

        unique case (r_state)
            hsk_pkg::ST_LOAD: begin
                if (accept) begin
                    ram.we    = stored;
                    ram.waddr = r_count[hsk_pkg::IDX_W-1:0];
                    ram.wdata = hsk_pkg::t_value'(i_s_tdata);
                    n_count   = total;
                    if (i_s_tlast) begin
                        n_count = '0;
                        n_size  = total;
                        n_n     = total;
                        n_j     = '0;
                        n_kpos  = (k_eff >= n_ext) ? '0
                                : hsk_pkg::t_idx'(n_ext - k_eff);
                        if (total > hsk_pkg::t_cnt'(1)) begin
                            n_b     = hsk_pkg::t_idx'((total - hsk_pkg::t_cnt'(2)) >> 1);
                            n_build = 1'b1;
                            n_state = hsk_pkg::ST_BSTART;
                        end else begin
                            n_state = hsk_pkg::ST_ORD;
                        end
                    end
                end
            end
            hsk_pkg::ST_BSTART: begin
                ram.raddr = r_b;
                n_state   = hsk_pkg::ST_BCUR;
            end
            hsk_pkg::ST_BCUR: begin
                n_cur   = i_ram_rdata;
                n_idx   = r_b;
                n_state = hsk_pkg::ST_RDL;
            end
            hsk_pkg::ST_RDL, hsk_pkg::ST_CMP: begin
                if (r_state == hsk_pkg::ST_RDL && l_ok) begin
                    ram.raddr = lc[hsk_pkg::IDX_W-1:0];
                    n_state   = hsk_pkg::ST_RDR;
                end else if (r_state == hsk_pkg::ST_CMP && big_val > r_cur) begin
                    // larger child moves up, hole moves down
                    ram.we    = 1'b1;
                    ram.wdata = big_val;
                    n_idx     = big_idx;
                    n_state   = hsk_pkg::ST_RDL;
                end else begin
                    // sift finished: drop the held value into the hole
                    ram.we = 1'b1;
                    if (r_build) begin
                        if (r_b == '0) begin
                            n_build = 1'b0;
                            n_state = hsk_pkg::ST_ERD0;
                        end else begin
                            n_b     = r_b - hsk_pkg::t_idx'(1);
                            n_state = hsk_pkg::ST_BSTART;
                        end
                    end else if (r_size > hsk_pkg::t_cnt'(1)) begin
                        n_state = hsk_pkg::ST_ERD0;
                    end else begin
                        n_state = hsk_pkg::ST_ORD;
                    end
                end
            end
            hsk_pkg::ST_RDR: begin
                ram.raddr = rc[hsk_pkg::IDX_W-1:0];
                n_lval    = i_ram_rdata;
                n_state   = hsk_pkg::ST_CMP;
            end
            hsk_pkg::ST_ERD0: begin
                ram.raddr = '0;
                n_state   = hsk_pkg::ST_ERDE;
            end
            hsk_pkg::ST_ERDE: begin
                ram.raddr = hsk_pkg::t_idx'(r_size - hsk_pkg::t_cnt'(1));
                n_lval    = i_ram_rdata;
                n_state   = hsk_pkg::ST_ESWAP;
            end
            hsk_pkg::ST_ESWAP: begin
                // old root goes to the end, old end becomes the held value
                ram.we    = 1'b1;
                ram.waddr = hsk_pkg::t_idx'(r_size - hsk_pkg::t_cnt'(1));
                ram.wdata = r_lval;
                n_cur     = i_ram_rdata;
                n_size    = r_size - hsk_pkg::t_cnt'(1);
                n_idx     = '0;
                n_state   = hsk_pkg::ST_RDL;
            end
            hsk_pkg::ST_ORD: begin
                ram.raddr = r_j;
                n_state   = hsk_pkg::ST_OWAIT;
            end
            hsk_pkg::ST_OWAIT: begin
                ram.raddr = r_j;
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = i_ram_rdata;
                    n_okth   = (r_j == r_kpos);
                    n_olast  = (hsk_pkg::t_cnt'(r_j) == last_cnt);
                    if (hsk_pkg::t_cnt'(r_j) == last_cnt) begin
                        n_state = hsk_pkg::ST_LOAD;
                    end else begin
                        n_j     = r_j + hsk_pkg::t_idx'(1);
                        n_state = hsk_pkg::ST_ORD;
                    end
                end
            end
            default: begin
                n_state = hsk_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hsk_pkg::ST_LOAD;
            r_count  <= '0;
            r_size   <= '0;
            r_n      <= '0;
            r_b      <= '0;
            r_idx    <= '0;
            r_j      <= '0;
            r_kpos   <= '0;
            r_build  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_size   <= n_size;
            r_n      <= n_n;
            r_b      <= n_b;
            r_idx    <= n_idx;
            r_j      <= n_j;
            r_kpos   <= n_kpos;
            r_build  <= n_build;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_lval  <= n_lval;
        r_odata <= n_odata;
        r_okth  <= n_okth;
        r_olast <= n_olast;
    end

    assign o_ram_req  = ram;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_okth;
    assign o_m_tlast  = r_olast;

endmodule

FILE: tb/heap_sort_with_kth_largest_tb.sv
`timescale 1ns / 100ps

module heap_sort_with_kth_largest_tb;

    // run guard: far above the slowest legal run (full sets, stalls on every
    // result, maximum source gaps)
    localparam int CYCLE_LIMIT  = 200_000;
    // quiet cycles after the last sorted transfer before the register moves
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        hsk_pkg::t_value value;
        logic            kth;
        logic            eor;
    } t_sorted_beat;

    // DUT ports
    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [31:0]                 i_s_tdata  = '0;   // [31:0] value
    logic                        i_s_tlast  = 1'b0; // last value of the set
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [31:0]                 o_m_tdata;         // [31:0] sorted_value
    logic                        o_m_tuser;         // [0] is_kth
    logic                        o_m_tlast;         // end_of_run
    logic                        i_psel     = 1'b0;
    logic                        i_penable  = 1'b0;
    logic                        i_pwrite   = 1'b0;
    logic [hsk_pkg::APB_AW-1:0]  i_paddr    = '0;
    logic [hsk_pkg::APB_DW-1:0]  i_pwdata   = '0;
    logic [hsk_pkg::APB_DW-1:0]  o_prdata;
    logic                        o_pready;

    // predictor state: values of the set being loaded, the rank in force,
    // and the sorted transfers still owed by the block
    hsk_pkg::t_value     set_values[$];
    hsk_pkg::t_rank      rank_shadow = 1;
    t_sorted_beat        sorted_due[$];

    // stimulus control
    hsk_pkg::t_value     stim_vals[$];
    bit                  allow_idle = 1'b1;
    bit                  sink_hold  = 1'b0;

    // bookkeeping
    int                  error_count    = 0;
    int                  items_sent     = 0;
    int                  sets_sent      = 0;
    int                  results_seen   = 0;
    int                  cycle_count    = 0;
    t_sorted_beat        want;

    heap_sort_with_kth_largest u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. Values are stored until the set holds MAX_ITEMS; later
    // ones are dropped. A tlast transfer closes the set even when its own
    // value was dropped. The closed set is ordered ascending and one
    // sorted transfer is owed per stored value. The flag sits at ascending
    // position count - k, with rank 0 acting as 1 and any rank at or above
    // the count landing on the smallest value.
    // ------------------------------------------------------------------
    function automatic void absorb_value(input hsk_pkg::t_value v, input bit last);
        hsk_pkg::t_value ordered[hsk_pkg::MAX_ITEMS];
        hsk_pkg::t_value key;
        t_sorted_beat    beat;
        int              n, k, kpos, i, j;
        if (set_values.size() < hsk_pkg::MAX_ITEMS)
            set_values.push_back(v);
        if (!last)
            return;
        n = set_values.size();
        for (i = 0; i < n; i++)
            ordered[i] = set_values[i];
        // insertion sort, signed compare
        for (i = 1; i < n; i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key) begin
                ordered[j+1] = ordered[j];
                j--;
            end
            ordered[j+1] = key;
        end
        k    = (rank_shadow == 0) ? 1 : int'(rank_shadow);
        kpos = (k >= n) ? 0 : n - k;
        for (i = 0; i < n; i++) begin
            beat.value = ordered[i];
            beat.kth   = (i == kpos);
            beat.eor   = (i == n - 1);
            sorted_due.push_back(beat);
        end
        set_values.delete();
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Checker: every sorted transfer against the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            results_seen++;
            if (sorted_due.size() == 0) begin
                report_mismatch($sformatf("unexpected sorted transfer, data %0d",
                                          $signed(o_m_tdata)));
            end else begin
                want = sorted_due.pop_front();
                if (o_m_tdata !== want.value)
                    report_mismatch($sformatf("sorted_value got %0d want %0d",
                                              $signed(o_m_tdata), want.value));
                if (o_m_tuser !== want.kth)
                    report_mismatch($sformatf("is_kth got %b want %b (value %0d)",
                                              o_m_tuser, want.kth, want.value));
                if (o_m_tlast !== want.eor)
                    report_mismatch($sformatf("end_of_run got %b want %b (value %0d)",
                                              o_m_tlast, want.eor, want.value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink ready: random stall bursts while idling is on,
    // forced low while a long hold is running.
    // ------------------------------------------------------------------
    initial begin : sink_ready_gen
        int  stall_left;
        bit  rdy;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (allow_idle && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_m_tready <= rdy;
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Source side. Tasks start and end at a falling edge. tvalid is left
    // high after a transfer so back-to-back transfers never toggle it
    // inside one step; source_quiet drops it when the source goes idle.
    // ------------------------------------------------------------------
    task automatic send_value(input hsk_pkg::t_value v, input bit last);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        absorb_value(v, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_stim_set();
        int i;
        for (i = 0; i < stim_vals.size(); i++)
            send_value(stim_vals[i], i == stim_vals.size() - 1);
        sets_sent++;
    endtask

    task automatic source_quiet();
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;
        @(negedge i_clk);
    endtask

    // block idle: nothing owed, then a few cycles for it to settle
    task automatic wait_idle();
        source_quiet();
        while (sorted_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup, then access until pready at a rising edge
    task automatic write_reg(input logic [hsk_pkg::APB_AW-1:0] addr,
                             input logic [hsk_pkg::APB_DW-1:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (o_pready !== 1'b1);
        if (addr == hsk_pkg::APB_AW'(4 * hsk_pkg::REG_KTH))
            rank_shadow = hsk_pkg::t_rank'(data);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    // upper write-data bits are junk; only the low seven hold the rank
    task automatic set_rank(input hsk_pkg::t_rank k);
        wait_idle();
        write_reg(hsk_pkg::APB_AW'(4 * hsk_pkg::REG_KTH),
                  {(hsk_pkg::APB_DW - hsk_pkg::RANK_W)'($urandom), k});
    endtask

    // 0: full 32-bit random, 1: narrow band (duplicates), 2: extremes, 3: random pick of these
    function automatic hsk_pkg::t_value rand_value(input int mode);
        int m;
        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        case (m)
            0: return hsk_pkg::t_value'($urandom);
            1: return hsk_pkg::t_value'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // single-value set and a set of field extremes at the reset rank
    task automatic test_extremes();
        stim_vals = '{32'sh8000_0000};
        send_stim_set();
        stim_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
                      32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA};
        send_stim_set();
    endtask

    // rank 0 behaves as rank 1: largest value flagged
    task automatic test_rank_zero();
        set_rank(0);
        stim_vals = '{32'sd3, -32'sd3, 32'sd3};
        send_stim_set();
    endtask

    // rank above the count, then equal to it: smallest value flagged
    task automatic test_rank_too_large();
        set_rank(64);
        stim_vals = '{32'sd10, -32'sd20, 32'sd30, 32'sd0};
        send_stim_set();
        set_rank(3);
        stim_vals = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000};
        send_stim_set();
    endtask

    // all values equal: exactly one flag, at position count - k
    task automatic test_equal_values();
        set_rank(2);
        stim_vals = '{32'sd7, 32'sd7, 32'sd7, 32'sd7};
        send_stim_set();
    endtask

    // 64 stored, then one plain value and the tlast value both dropped
    task automatic test_full_set();
        int i;
        set_rank(5);
        stim_vals.delete();
        for (i = 0; i < hsk_pkg::MAX_ITEMS + 2; i++)
            stim_vals.push_back(rand_value(3));
        send_stim_set();
    endtask

    // sink frozen for a long stretch while two sets are offered back to
    // back: the first sorts and parks, the second backs up the input
    task automatic test_output_stall();
        int i;
        set_rank(2);
        fork
            begin
                sink_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold = 1'b0;
            end
        join_none
        repeat (2) begin
            stim_vals.delete();
            for (i = 0; i < 8; i++)
                stim_vals.push_back(rand_value(0));
            send_stim_set();
        end
    endtask

    // random sets, mostly small; rank rewritten between some of them,
    // otherwise sets follow one another while the previous one drains
    task automatic test_random_sets(input int item_goal);
        int             n, mode, i;
        hsk_pkg::t_rank k;
        while (items_sent < item_goal) begin
            n = ($urandom_range(0, 14) == 0) ? $urandom_range(33, hsk_pkg::MAX_ITEMS)
                                             : $urandom_range(1, 12);
            if (n > item_goal - items_sent)
                n = item_goal - items_sent;
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0: k = 0;
                    1: k = 1;
                    2: k = hsk_pkg::t_rank'(n);
                    3: k = hsk_pkg::t_rank'(n - 1);
                    4: k = hsk_pkg::t_rank'(n + 1);
                    5: k = 64;
                    6: k = 127;
                    default: k = hsk_pkg::t_rank'($urandom_range(0, 127));
                endcase
                set_rank(k);
            end
            mode = $urandom_range(0, 3);
            stim_vals.delete();
            for (i = 0; i < n; i++)
                stim_vals.push_back(rand_value(mode));
            send_stim_set();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_calm_sets(input int item_goal);
        allow_idle = 1'b0;
        test_random_sets(item_goal);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_rank_zero();
        test_rank_too_large();
        test_equal_values();
        test_full_set();
        test_output_stall();
        test_random_sets(items_sent + 50);
        test_calm_sets(items_sent + 16);

        wait_idle();
        repeat (32) @(posedge i_clk);

        $display("Summary: %0d sets, %0d values sent, %0d sorted transfers checked,",
                 sets_sent, items_sent, results_seen);
        $display("  ranks 0..127 incl. extremes, set-full drops, long output hold.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
